### hw/rtl/sorted_table_indexed_search_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search core
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INDEXED_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_INDEXED_SEARCH_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define STIS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define STIS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define STIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/stis_pkg.sv
// ----------------------------------------------------------------------------
// stis_pkg
// Types, sizes and command/status codes of the sorted table search core.
// ----------------------------------------------------------------------------
package stis_pkg;

    localparam int CAPACITY    = 64;
    localparam int STRIDE      = 5;
    localparam int VALUE_WIDTH = 32;

    // Table address, entry count and walk pointer widths
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = 7;
    localparam int PTR_W  = $clog2(CAPACITY + STRIDE + 1);

    // Stream word layout
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int KEY_W       = 32;
    localparam int OUT_TDATA_W = ((2 * CNT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * CNT_W;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INS   = 7'b0000010,
        S_LIN   = 7'b0000100,
        S_IDX   = 7'b0001000,
        S_WALK  = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage

### hw/rtl/sorted_table_indexed_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_indexed_search_core
// Sorted table of signed values with insert, remove and indexed search.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one command word: tuser carries the command
//   (insert, remove, search), tdata the signed key. The master stream
//   returns exactly one word per command: tuser is the status (done/found,
//   not found, table full), tdata holds the one-based position and the
//   entry count after the command.
//   The table lives in one 64 x 32 synchronous memory with a registered read;
//   every step of a command is one memory read plus at most one write:
//   insert moves each larger entry up one place and then writes the key,
//   a short table is scanned from the front, an indexed search reads the
//   index points and walks back over the entries, and a remove runs as
//   a search and then pulls the entries behind the hit down one place.
//   One command is worked on at a time; tready is high while idle.
//   Reset clears the entry count and all control state; the memory is not
//   cleared since only entries below the count are ever used.
//   A stalled receiver holds the result in the output register; the next
//   command is still accepted and run, then waits until the output drains.
// ----------------------------------------------------------------------------
`include "sorted_table_indexed_search_core_defines.svh"

module sorted_table_indexed_search_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_axis_tdata: key[31:0]
    input  logic [stis_pkg::KEY_W-1:0]        s_axis_tdata,
    // s_axis_tuser: cmd[1:0]
    input  logic [stis_pkg::CMD_W-1:0]        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // m_axis_tdata: position[6:0], fill[13:7], zero pad[15:14]
    output logic [stis_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // m_axis_tuser: status[1:0]
    output logic [stis_pkg::STATUS_W-1:0]     m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);
    import stis_pkg::*;

    state_t                 state_reg, state_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    value_t                 key_reg, key_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [CNT_W-1:0]       out_pos_reg;
    logic [CNT_W-1:0]       out_fill_reg;
    logic                   out_load;

    value_t                 mem [CAPACITY];
    value_t                 rd_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    value_t                 mem_wd;

    logic                   in_accept;
    logic                   hit;
    logic                   miss;
    logic [PTR_W-1:0]       cnt_ext;
    logic [PTR_W-1:0]       ptr_step;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cnt_ext = PTR_W'(cnt_reg);
    assign ptr_step = ptr_reg + PTR_W'(STRIDE);

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[rd_addr];
    end

    // Command sequencer: each step consumes the word read in the last cycle
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        mem_we      = 1'b0;
        mem_wa      = ptr_reg[ADDR_W-1:0];
        mem_wd      = rd_data;
        rd_addr     = ptr_reg[ADDR_W-1:0];
        hit         = 1'b0;
        miss        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next = s_axis_tuser;
                    key_next = value_t'(s_axis_tdata);
                    pos_next = '0;
                    unique case (s_axis_tuser) inside
                        CMD_INSERT:
                        begin
                            if (cnt_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = cnt_ext;
                                rd_addr    = ADDR_W'(cnt_reg - 1'b1);
                                state_next = S_INS;
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                miss = 1'b1;
                            end
                            else if (cnt_reg < CNT_W'(STRIDE))
                            begin
                                ptr_next   = '0;
                                rd_addr    = '0;
                                state_next = S_LIN;
                            end
                            else
                            begin
                                ptr_next   = PTR_W'(STRIDE - 1);
                                rd_addr    = ADDR_W'(STRIDE - 1);
                                state_next = S_IDX;
                            end
                        end
                        default:
                        begin
                            miss = 1'b1;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // Move larger entries up one place, then drop the key in
                mem_we = 1'b1;
                if (ptr_reg != '0 && key_reg < rd_data)
                begin
                    mem_wd   = rd_data;
                    ptr_next = ptr_reg - 1'b1;
                    rd_addr  = ADDR_W'(ptr_reg - PTR_W'(2));
                end
                else
                begin
                    mem_wd      = key_reg;
                    cnt_next    = cnt_reg + 1'b1;
                    pos_next    = CNT_W'(ptr_reg + 1'b1);
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end

            S_LIN:
            begin
                // Short table: first equal entry from the front
                if (rd_data == key_reg)
                begin
                    hit = 1'b1;
                end
                else if (ptr_reg + 1'b1 == cnt_ext)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rd_addr  = ADDR_W'(ptr_reg + 1'b1);
                end
            end

            S_IDX:
            begin
                // Advance over index points below the key
                if (key_reg > rd_data)
                begin
                    if (ptr_step < cnt_ext)
                    begin
                        ptr_next = ptr_step;
                        rd_addr  = ptr_step[ADDR_W-1:0];
                    end
                    else
                    begin
                        ptr_next   = cnt_ext - 1'b1;
                        rd_addr    = ADDR_W'(cnt_reg - 1'b1);
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                // Walk back while the key is below the entry
                if (key_reg < rd_data)
                begin
                    if (ptr_reg == '0)
                    begin
                        miss = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - 1'b1;
                        rd_addr  = ADDR_W'(ptr_reg - 1'b1);
                    end
                end
                else if (rd_data == key_reg)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    miss = 1'b1;
                end
            end

            S_SHIFT:
            begin
                // Close the gap: pull each following entry down one place
                mem_we = 1'b1;
                mem_wd = rd_data;
                if (ptr_reg + PTR_W'(2) < cnt_ext)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rd_addr  = ADDR_W'(ptr_reg + PTR_W'(2));
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Settle a found or missing entry
        if (miss)
        begin
            status_next = ST_NOT_FOUND;
            pos_next    = '0;
            state_next  = S_DONE;
        end
        if (hit)
        begin
            status_next = ST_OK;
            pos_next    = CNT_W'(ptr_reg + 1'b1);
            state_next  = S_DONE;
            if (cmd_reg == CMD_REMOVE)
            begin
                if (ptr_reg + 1'b1 < cnt_ext)
                begin
                    rd_addr    = ADDR_W'(ptr_reg + 1'b1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    // Output register: load a finished result once the slot is free
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_pos_reg    <= pos_reg;
            out_fill_reg   <= cnt_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_fill_reg, out_pos_reg};

    // Checks
    `STIS_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(CAPACITY),
        "entry count above capacity")
    `STIS_ASSERT_SAME(a_we_states, mem_we, state_reg == S_INS || state_reg == S_SHIFT,
        "table written outside insert or shift")
    `STIS_ASSERT_SAME(a_ins_ptr, state_reg == S_INS, ptr_reg <= cnt_ext,
        "insert pointer past the entry count")
    `STIS_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != S_IDLE,
        "accepted command did not start")

endmodule

### dv/table_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply checker for the sorted table search core
// Watches both stream channels, keeps its own copy of the sorted table,
// works out the reply of every accepted command and compares it field by
// field with the reply words that the core hands out, in order.
// ----------------------------------------------------------------------------
module table_reply_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [stis_pkg::KEY_W-1:0]        s_axis_tdata,
    input  logic [stis_pkg::CMD_W-1:0]        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [stis_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [stis_pkg::STATUS_W-1:0]     m_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output int                                mismatch_count,
    output int                                replies_pending
);
    import stis_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [CNT_W-1:0]    position;
        logic [CNT_W-1:0]    fill;
    } reply_t;

    // Shadow copy of the table: ascending values and the entry count
    value_t table_values [CAPACITY];
    int     table_fill;

    reply_t expected_replies [$];

    // Zero-based slot holding the key, or -1; linear scan on short tables,
    // index points every STRIDE entries plus the last entry otherwise
    function automatic int find_slot(input value_t key);
        int n;
        int j;
        int points;
        int p;
        n = table_fill;
        if (n < STRIDE)
        begin
            for (j = 0; j < n; j++)
            begin
                if (table_values[j] == key)
                    return j;
            end
            return -1;
        end
        points = n / STRIDE;
        p = 0;
        while (p < points && key > table_values[(p + 1) * STRIDE - 1])
            p++;
        j = (p < points) ? (p + 1) * STRIDE - 1 : n - 1;
        // walk back toward the front while the key is smaller
        while (j >= 0)
        begin
            if (!(key < table_values[j]))
                break;
            j--;
        end
        if (j >= 0 && table_values[j] == key)
            return j;
        return -1;
    endfunction

    // Apply one command to the shadow table and return its reply
    function automatic reply_t predict_reply(input logic [CMD_W-1:0] cmd,
                                             input value_t key);
        reply_t r;
        int     k;
        int     hit;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        case (cmd) inside
            CMD_INSERT:
            begin
                if (table_fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // place after any equal values
                    k = table_fill;
                    while (k > 0 && key < table_values[k - 1])
                    begin
                        table_values[k] = table_values[k - 1];
                        k--;
                    end
                    table_values[k] = key;
                    table_fill++;
                    r.status   = ST_OK;
                    r.position = CNT_W'(k + 1);
                end
            end
            CMD_REMOVE, CMD_SEARCH:
            begin
                hit = find_slot(key);
                if (hit >= 0)
                begin
                    r.status   = ST_OK;
                    r.position = CNT_W'(hit + 1);
                    if (cmd == CMD_REMOVE)
                    begin
                        // close the gap
                        for (k = hit; k + 1 < table_fill; k++)
                            table_values[k] = table_values[k + 1];
                        table_fill--;
                    end
                end
            end
            default:
            begin
                // unused command code leaves the table alone
            end
        endcase
        r.fill = CNT_W'(table_fill);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            table_fill = 0;
            expected_replies.delete();
            replies_pending = 0;
        end
        else
        begin
            // compare a reply word before taking in a new command word
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply word with no command pending: tuser=%0d tdata=%h",
                           m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[CNT_W-1:0] !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, m_axis_tdata[CNT_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[2*CNT_W-1:CNT_W] !== want.fill)
                    begin
                        $error("fill: expected %0d, actual %0d",
                               want.fill, m_axis_tdata[2*CNT_W-1:CNT_W]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:2*CNT_W] !== '0)
                    begin
                        $error("pad: expected 0, actual %0h",
                               m_axis_tdata[OUT_TDATA_W-1:2*CNT_W]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_reply(s_axis_tuser, value_t'(s_axis_tdata));
                expected_replies.push_back(want);
            end
            replies_pending = expected_replies.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted table search core
// Drives insert, remove and search words: a directed opening over empty,
// short and indexed tables and the key extremes, then random runs that grow
// the table to full and drain it again, under three idling patterns and one
// long receiver hold. The reply checker gives the verdict input.
// ----------------------------------------------------------------------------
module testbench;

    import stis_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_WORDS  = 730;
    localparam int SEGMENT_WORDS = 90;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int STALL_LIMIT   = 5000;

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_BALANCED } mix_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic [KEY_W-1:0]        s_axis_tdata = '0;
    logic [CMD_W-1:0]        s_axis_tuser = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;

    int mismatch_count;
    int replies_pending;
    int load_phase = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;

    logic [KEY_W-1:0] inserted_keys [$];

    sorted_table_indexed_search_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    table_reply_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // Offer one command word and hold it until the core takes it
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= key;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd == CMD_INSERT)
        begin
            inserted_keys.push_back(key);
            if (inserted_keys.size() > 128)
                void'(inserted_keys.pop_front());
        end
    endtask

    // Mostly small keys so that duplicates and hits are common
    function automatic logic [KEY_W-1:0] pick_key(input bit reuse);
        int roll;
        logic [KEY_W-1:0] k;
        roll = $urandom_range(0, 99);
        if (reuse && inserted_keys.size() > 0 && roll < 50)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            k = $urandom_range(0, 40);
            return k - 32'd20;
        end
        if (roll < 62)
        begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                3: return 32'hffff_ffff;
                4: return 32'h8000_0001;
                default: return 32'h7fff_fffe;
            endcase
        end
        return $urandom;
    endfunction

    // Receiver: random back-pressure, with one long hold at the last phase
    initial
    begin : rx_drive
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (load_phase == 2 && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run when no word moves for too long
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int   n;
        int   roll;
        mix_t mix;
        logic [CMD_W-1:0] cmd;

        mix = MIX_GROW;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, unused code, short and indexed searches
        tx_idle_pct = 22;
        rx_idle_pct = 60;
        send_word(CMD_SEARCH, 32'd0);
        send_word(CMD_REMOVE, 32'd7);
        send_word(CMD_UNUSED, 32'd0);
        send_word(CMD_INSERT, 32'd10);
        send_word(CMD_INSERT, 32'd20);
        send_word(CMD_SEARCH, 32'd5);
        send_word(CMD_INSERT, 32'd30);
        send_word(CMD_INSERT, 32'd40);
        send_word(CMD_INSERT, 32'd50);
        // key below every entry runs the walk off the front
        send_word(CMD_SEARCH, 32'd5);
        send_word(CMD_SEARCH, 32'd50);
        send_word(CMD_SEARCH, 32'd40);
        // key above every entry falls back to the last entry
        send_word(CMD_SEARCH, 32'd60);
        send_word(CMD_INSERT, 32'd30);
        send_word(CMD_REMOVE, 32'd30);
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_SEARCH, 32'h7fff_ffff);
        send_word(CMD_SEARCH, 32'h8000_0000);
        send_word(CMD_REMOVE, 32'h8000_0000);
        send_word(CMD_REMOVE, 32'd35);
        send_word(CMD_UNUSED, 32'hffff_ffff);

        // Random: segments that grow, shrink or churn the table
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            load_phase = (n * 3) / RANDOM_WORDS;
            case (load_phase)
                0:
                begin
                    tx_idle_pct = 22;
                    rx_idle_pct = 60;
                end
                1:
                begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 22;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (n % SEGMENT_WORDS == 0 && n != 0)
                mix = mix_t'($urandom_range(0, 2));
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_GROW:
                    cmd = (roll < 85) ? CMD_INSERT : (roll < 92) ? CMD_REMOVE : CMD_SEARCH;
                MIX_SHRINK:
                    cmd = (roll < 15) ? CMD_INSERT : (roll < 75) ? CMD_REMOVE : CMD_SEARCH;
                default:
                    cmd = (roll < 34) ? CMD_INSERT : (roll < 67) ? CMD_REMOVE : CMD_SEARCH;
            endcase
            if ($urandom_range(0, 99) == 0)
                cmd = CMD_UNUSED;
            send_word(cmd, pick_key(cmd != CMD_INSERT));
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding replies, then allow time for stray words
        while (replies_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
